FILE: rtl/cfp_pkg.sv
// shared types and constants for the class file stream parser
package cfp_pkg;

    localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;

    localparam int PHASE_W = 26;

    typedef enum logic [PHASE_W-1:0] {
        PH_MAGIC  = 26'd1 << 0,
        PH_MINOR  = 26'd1 << 1,
        PH_MAJOR  = 26'd1 << 2,
        PH_PCOUNT = 26'd1 << 3,
        PH_TAG    = 26'd1 << 4,
        PH_PA     = 26'd1 << 5,
        PH_PB     = 26'd1 << 6,
        PH_RKIND  = 26'd1 << 7,
        PH_HI     = 26'd1 << 8,
        PH_LO     = 26'd1 << 9,
        PH_ULEN   = 26'd1 << 10,
        PH_USKIP  = 26'd1 << 11,
        PH_ACCESS = 26'd1 << 12,
        PH_THIS   = 26'd1 << 13,
        PH_SUPER  = 26'd1 << 14,
        PH_ICOUNT = 26'd1 << 15,
        PH_IFACE  = 26'd1 << 16,
        PH_TCOUNT = 26'd1 << 17,
        PH_MACC   = 26'd1 << 18,
        PH_MNAME  = 26'd1 << 19,
        PH_MDESC  = 26'd1 << 20,
        PH_ACOUNT = 26'd1 << 21,
        PH_ANAME  = 26'd1 << 22,
        PH_ALEN   = 26'd1 << 23,
        PH_ASKIP  = 26'd1 << 24,
        PH_DONE   = 26'd1 << 25
    } phase_t;

    typedef enum logic [4:0] {
        K_MAGIC = 5'd0, K_MINOR = 5'd1, K_MAJOR = 5'd2, K_PCOUNT = 5'd3,
        K_TAG = 5'd4, K_PA = 5'd5, K_PB = 5'd6, K_HI = 5'd7, K_LO = 5'd8,
        K_RKIND = 5'd9, K_ULEN = 5'd10, K_ACCESS = 5'd11, K_THIS = 5'd12,
        K_SUPER = 5'd13, K_ICOUNT = 5'd14, K_IFACE = 5'd15, K_FCOUNT = 5'd16,
        K_MCOUNT = 5'd17, K_MACC = 5'd18, K_MNAME = 5'd19, K_MDESC = 5'd20,
        K_ACOUNT = 5'd21, K_ANAME = 5'd22, K_ALEN = 5'd23
    } kind_t;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_MAGIC   = 2'd1;
    localparam logic [1:0] ERR_BAD_TAG = 2'd2;

    localparam logic [1:0] SEC_FIELDS  = 2'd0;
    localparam logic [1:0] SEC_METHODS = 2'd1;
    localparam logic [1:0] SEC_CLASS   = 2'd2;

    localparam logic [7:0] TAG_UTF8    = 8'd1;
    localparam logic [7:0] TAG_LONG    = 8'd5;
    localparam logic [7:0] TAG_DOUBLE  = 8'd6;
    localparam logic [7:0] TAG_MHANDLE = 8'd15;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic [15:0] index;
        logic [7:0]  tag;
        logic [1:0]  err;
        logic        done;
    } token_t;

    function automatic logic [2:0] phase_width(input phase_t p);
        logic [2:0] w;
        w = 3'd2;
        if (p == PH_MAGIC || p == PH_HI || p == PH_LO || p == PH_ALEN) w = 3'd4;
        else if (p == PH_TAG || p == PH_RKIND) w = 3'd1;
        return w;
    endfunction

    function automatic logic tag_has_second(input logic [7:0] t);
        return (t >= 8'd9 && t <= 8'd12) || t == 8'd17 || t == 8'd18;
    endfunction

endpackage

FILE: rtl/cfp_parse.sv
// parse state machine: one byte in, at most one token out per beat
module cfp_parse
    import cfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       restart,
    output logic       tok_valid,
    output token_t     tok
);

    phase_t      phase_reg, phase_next, ph;
    logic [2:0]  bif_reg, bif_next, bif;
    logic [31:0] acc_reg, acc_next, acc;
    logic [15:0] pool_reg, pool_next_v, pool;
    logic [15:0] tab_reg, tab_next, tab;
    logic [15:0] attr_reg, attr_next, attr;
    logic [31:0] skip_reg, skip_next, skip;
    logic [15:0] idx_reg, idx_next, cidx;
    logic [7:0]  ctag_reg, ctag_next, ctag;
    logic [1:0]  sec_reg, sec_next, sec;
    logic        halt_reg, halt_next, halt;
    logic [15:0] aidx_reg, aidx_next, aidx;
    logic [31:0] val;
    logic [31:0] acc_sh;
    logic [2:0]  bif_inc;
    logic [15:0] slots;
    logic [15:0] tab_dec;
    logic [15:0] attr_dec;
    logic [31:0] skip_dec;

    always_comb begin
        ph   = restart ? PH_MAGIC : phase_reg;
        bif  = restart ? 3'd0 : bif_reg;
        acc  = restart ? 32'd0 : acc_reg;
        pool = restart ? 16'd0 : pool_reg;
        tab  = restart ? 16'd0 : tab_reg;
        attr = restart ? 16'd0 : attr_reg;
        skip = restart ? 32'd0 : skip_reg;
        cidx = restart ? 16'd0 : idx_reg;
        ctag = restart ? 8'd0 : ctag_reg;
        sec  = restart ? 2'd0 : sec_reg;
        halt = restart ? 1'b0 : halt_reg;
        aidx = restart ? 16'd0 : aidx_reg;

        phase_next = ph;  bif_next = bif;  acc_next = acc;  pool_next_v = pool;
        tab_next = tab;   attr_next = attr; skip_next = skip; idx_next = cidx;
        ctag_next = ctag; sec_next = sec;  halt_next = halt; aidx_next = aidx;
        tok_valid = 1'b0;
        tok = '0;

        acc_sh   = {acc[23:0], data_byte};
        bif_inc  = bif + 3'd1;
        val      = acc_sh;
        slots    = (ctag == TAG_LONG || ctag == TAG_DOUBLE) ? 16'd2 : 16'd1;
        tab_dec  = tab - 16'd1;
        attr_dec = attr - 16'd1;
        skip_dec = skip - 32'd1;

        if (halt || ph == PH_DONE) begin
        end else if (ph == PH_USKIP || ph == PH_ASKIP) begin
            skip_next = skip_dec;
            if (skip_dec == 32'd0) begin
                if (ph == PH_USKIP) begin
                    idx_next = cidx + slots;
                    if (pool <= slots) begin
                        pool_next_v = '0; ctag_next = '0; idx_next = '0;
                        phase_next = PH_ACCESS;
                    end else begin
                        pool_next_v = pool - slots; phase_next = PH_TAG;
                    end
                end else begin
                    aidx_next = aidx + 16'd1;
                    attr_next = attr_dec;
                    if (attr_dec != 16'd0) phase_next = PH_ANAME;
                    else if (sec >= SEC_CLASS) phase_next = PH_DONE;
                    else begin
                        idx_next = cidx + 16'd1;
                        tab_next = tab_dec;
                        if (tab_dec != 16'd0) phase_next = PH_MACC;
                        else begin
                            idx_next = '0;
                            sec_next = (sec == SEC_FIELDS) ? SEC_METHODS : SEC_CLASS;
                            phase_next = (sec == SEC_FIELDS) ? PH_TCOUNT : PH_ACOUNT;
                        end
                    end
                end
            end
        end else if (bif_inc < phase_width(ph)) begin
            acc_next = acc_sh;
            bif_next = bif_inc;
        end else begin
            acc_next = '0;
            bif_next = '0;
            tok_valid = 1'b1;
            tok.value = val;
            unique case (ph)
                PH_MAGIC: begin
                    tok.kind = K_MAGIC;
                    if (val != MAGIC_WORD) begin
                        tok.err = ERR_MAGIC; halt_next = 1'b1;
                    end else phase_next = PH_MINOR;
                end
                PH_MINOR: begin tok.kind = K_MINOR; phase_next = PH_MAJOR; end
                PH_MAJOR: begin tok.kind = K_MAJOR; phase_next = PH_PCOUNT; end
                PH_PCOUNT: begin
                    tok.kind = K_PCOUNT;
                    ctag_next = '0;
                    if (val <= 32'd1) begin
                        pool_next_v = '0; idx_next = '0; phase_next = PH_ACCESS;
                    end else begin
                        idx_next = 16'd1;
                        pool_next_v = val[15:0] - 16'd1; phase_next = PH_TAG;
                    end
                end
                PH_TAG: begin
                    tok.kind = K_TAG; tok.index = cidx; tok.tag = val[7:0];
                    ctag_next = val[7:0];
                    if (val[7:0] == TAG_UTF8) phase_next = PH_ULEN;
                    else if (val[7:0] >= 8'd3 && val[7:0] <= 8'd6) phase_next = PH_HI;
                    else if ((val[7:0] >= 8'd7 && val[7:0] <= 8'd12)
                             || (val[7:0] >= 8'd16 && val[7:0] <= 8'd20))
                        phase_next = PH_PA;
                    else if (val[7:0] == TAG_MHANDLE) phase_next = PH_RKIND;
                    else begin tok.err = ERR_BAD_TAG; halt_next = 1'b1; end
                end
                PH_PA, PH_PB, PH_RKIND, PH_HI, PH_LO, PH_ULEN: begin
                    tok.index = cidx; tok.tag = ctag;
                    tok.kind = (ph == PH_PA) ? K_PA : (ph == PH_PB) ? K_PB :
                               (ph == PH_RKIND) ? K_RKIND : (ph == PH_HI) ? K_HI :
                               (ph == PH_LO) ? K_LO : K_ULEN;
                    if (ph == PH_RKIND) phase_next = PH_PA;
                    else if (ph == PH_PA && tag_has_second(ctag)) phase_next = PH_PB;
                    else if (ph == PH_HI && (ctag == TAG_LONG || ctag == TAG_DOUBLE))
                        phase_next = PH_LO;
                    else if (ph == PH_ULEN && val != 32'd0) begin
                        skip_next = val; phase_next = PH_USKIP;
                    end else begin
                        idx_next = cidx + slots;
                        if (pool <= slots) begin
                            pool_next_v = '0; ctag_next = '0; idx_next = '0;
                            phase_next = PH_ACCESS;
                        end else begin
                            pool_next_v = pool - slots; phase_next = PH_TAG;
                        end
                    end
                end
                PH_ACCESS: begin tok.kind = K_ACCESS; phase_next = PH_THIS; end
                PH_THIS:   begin tok.kind = K_THIS; phase_next = PH_SUPER; end
                PH_SUPER:  begin tok.kind = K_SUPER; phase_next = PH_ICOUNT; end
                PH_ICOUNT: begin
                    tok.kind = K_ICOUNT;
                    tab_next = val[15:0]; idx_next = '0; sec_next = SEC_FIELDS;
                    phase_next = (val == 32'd0) ? PH_TCOUNT : PH_IFACE;
                end
                PH_IFACE: begin
                    tok.kind = K_IFACE; tok.index = cidx;
                    idx_next = cidx + 16'd1;
                    tab_next = tab_dec;
                    if (tab_dec == 16'd0) begin
                        idx_next = '0; phase_next = PH_TCOUNT;
                    end
                end
                PH_TCOUNT: begin
                    tok.kind = (sec == SEC_FIELDS) ? K_FCOUNT : K_MCOUNT;
                    tab_next = val[15:0]; idx_next = '0;
                    if (val == 32'd0) begin
                        sec_next = (sec == SEC_FIELDS) ? SEC_METHODS : SEC_CLASS;
                        phase_next = (sec == SEC_FIELDS) ? PH_TCOUNT : PH_ACOUNT;
                    end else phase_next = PH_MACC;
                end
                PH_MACC:  begin tok.kind = K_MACC; tok.index = cidx; phase_next = PH_MNAME; end
                PH_MNAME: begin tok.kind = K_MNAME; tok.index = cidx; phase_next = PH_MDESC; end
                PH_MDESC: begin tok.kind = K_MDESC; tok.index = cidx; phase_next = PH_ACOUNT; end
                PH_ACOUNT: begin
                    tok.kind = K_ACOUNT;
                    tok.index = (sec < SEC_CLASS) ? cidx : 16'd0;
                    attr_next = val[15:0]; aidx_next = '0;
                    if (val == 32'd0) begin
                        if (sec >= SEC_CLASS) begin
                            tok.done = 1'b1; phase_next = PH_DONE;
                        end else begin
                            idx_next = cidx + 16'd1;
                            tab_next = tab_dec;
                            if (tab_dec != 16'd0) phase_next = PH_MACC;
                            else begin
                                idx_next = '0;
                                sec_next = (sec == SEC_FIELDS) ? SEC_METHODS : SEC_CLASS;
                                phase_next = (sec == SEC_FIELDS) ? PH_TCOUNT : PH_ACOUNT;
                            end
                        end
                    end else phase_next = PH_ANAME;
                end
                PH_ANAME: begin tok.kind = K_ANAME; tok.index = aidx; phase_next = PH_ALEN; end
                default: begin
                    tok.kind = K_ALEN; tok.index = aidx;
                    if (sec >= SEC_CLASS && attr == 16'd1) tok.done = 1'b1;
                    if (val != 32'd0) begin
                        skip_next = val; phase_next = PH_ASKIP;
                    end else begin
                        aidx_next = aidx + 16'd1;
                        attr_next = attr_dec;
                        if (attr_dec != 16'd0) phase_next = PH_ANAME;
                        else if (sec >= SEC_CLASS) phase_next = PH_DONE;
                        else begin
                            idx_next = cidx + 16'd1;
                            tab_next = tab_dec;
                            if (tab_dec != 16'd0) phase_next = PH_MACC;
                            else begin
                                idx_next = '0;
                                sec_next = (sec == SEC_FIELDS) ? SEC_METHODS : SEC_CLASS;
                                phase_next = (sec == SEC_FIELDS) ? PH_TCOUNT : PH_ACOUNT;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;
            bif_reg   <= '0;
            acc_reg   <= '0;
            pool_reg  <= '0;
            tab_reg   <= '0;
            attr_reg  <= '0;
            skip_reg  <= '0;
            idx_reg   <= '0;
            ctag_reg  <= '0;
            sec_reg   <= '0;
            halt_reg  <= 1'b0;
            aidx_reg  <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            bif_reg   <= bif_next;
            acc_reg   <= acc_next;
            pool_reg  <= pool_next_v;
            tab_reg   <= tab_next;
            attr_reg  <= attr_next;
            skip_reg  <= skip_next;
            idx_reg   <= idx_next;
            ctag_reg  <= ctag_next;
            sec_reg   <= sec_next;
            halt_reg  <= halt_next;
            aidx_reg  <= aidx_next;
        end
    end

    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg)) else $error("phase not one-hot");
    a_bif_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bif_reg < 3'd4) else $error("byte count out of range");
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (halt_reg && !restart) |-> !tok_valid) else $error("token while halted");
    a_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && tok_valid && tok.err != ERR_NONE) |=> halt_reg)
        else $error("error did not halt");
    a_sec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_reg != 2'd3) else $error("bad section");

endmodule

FILE: rtl/cfp_out_buf.sv
// two-entry skid output buffer for tokens
module cfp_out_buf
    import cfp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    input  token_t in_tok,
    output logic   space,
    output logic   out_valid,
    output token_t out_tok,
    input  logic   out_ready
);

    token_t main_reg, skid_reg;
    logic   mv_reg, sv_reg;
    logic   pop;

    assign pop       = mv_reg && out_ready;
    assign space     = !sv_reg;
    assign out_valid = mv_reg;
    assign out_tok   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
            sv_reg <= 1'b0;
        end else begin
            if (!mv_reg || pop) begin
                mv_reg <= sv_reg || in_valid;
                sv_reg <= 1'b0;
            end else if (in_valid) begin
                sv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!mv_reg || pop) begin
            main_reg <= sv_reg ? skid_reg : in_tok;
        end
        if (in_valid && !(!mv_reg || pop)) skid_reg <= in_tok;
        else if (in_valid && sv_reg) skid_reg <= in_tok;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (sv_reg && !pop) |-> !in_valid) else $error("buffer overflow");
    a_skid_implies_main: assert property (@(posedge aclk) disable iff (!aresetn)
        sv_reg |-> mv_reg) else $error("skid without main");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !out_ready) |=> (mv_reg && $stable(main_reg)))
        else $error("token changed while stalled");

endmodule

FILE: rtl/class_file_stream_parser.sv
// top level: class file byte stream parser
// a token is registered in the output buffer: main slot, or skid slot while m_ stalls
// throughput: one byte per cycle; tready falls only while both output slots are full
// reset: aresetn synchronous active low; parse returns to expecting the magic word
// s_tuser restart also clears the parse before the byte in that beat
module class_file_stream_parser
    import cfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // field_kind[4:0], field_value[36:5], entry_index[52:37],
                                   // pool_tag[60:53], error_code[62:61], zero
    output logic        m_tlast    // file_done
);

    logic   step, tok_valid, space;
    token_t tok, otok;

    assign s_tready = space;
    assign step     = s_tvalid && s_tready;

    cfp_parse u_parse (
        .aclk(aclk), .aresetn(aresetn), .step(step),
        .data_byte(s_tdata), .restart(s_tuser),
        .tok_valid(tok_valid), .tok(tok)
    );

    cfp_out_buf u_buf (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(step && tok_valid), .in_tok(tok),
        .space(space), .out_valid(m_tvalid), .out_tok(otok), .out_ready(m_tready)
    );

    assign m_tdata = {1'b0, otok.err, otok.tag, otok.index, otok.value, otok.kind};
    assign m_tlast = otok.done;

endmodule
